FILE: hdl/krpm_pkg.sv
// Shared types and constants for the kill rule priority match block.
// Depends on nothing; krpm_in_if, krpm_judge and the top level import it.
package krpm_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 8192;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int ID_W       = 64;
    localparam int TIME_W     = 40;
    localparam int LIMIT_W    = 20;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;

    // Configuration register indexes, decoded from paddr[3]
    localparam logic CFG_IDX_STALE_LIMIT = 1'b0;
    localparam logic CFG_IDX_NOW_TIME    = 1'b1;

    // Reset values of the configuration registers
    localparam logic [LIMIT_W-1:0] STALE_LIMIT_RST = LIMIT_W'(300);
    localparam logic [TIME_W-1:0]  NOW_TIME_RST    = '0;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_JUDGE  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        SCOPE_NONE       = 2'd0,
        SCOPE_ALL        = 2'd1,
        SCOPE_INSTRUMENT = 2'd2,
        SCOPE_CUSTOMER   = 2'd3
    } scope_t;

    typedef enum logic [2:0] {
        DEC_ACCEPT          = 3'd0,
        DEC_KILL_ALL        = 3'd1,
        DEC_KILL_INSTRUMENT = 3'd2,
        DEC_KILL_CUSTOMER   = 3'd3,
        DEC_FAIL_CLOSED     = 3'd4
    } decision_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // One stored rule, as one memory word
    typedef struct packed {
        logic [1:0]        scope;
        logic              active;
        logic [ID_W-1:0]   instrument;
        logic [ID_W-1:0]   customer;
        logic [TIME_W-1:0] upd_time;
    } rule_t;

    // Control from the sequencer to the evaluator
    typedef struct packed {
        logic start;
        logic eval;
    } judge_ctl_t;

endpackage

FILE: hdl/krpm_in_if.sv
// Command channel of the kill rule block: valid/ready plus one command word.
// Depends on krpm_pkg for field widths.
interface krpm_in_if;
    import krpm_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [1:0]        scope;
    logic [ID_W-1:0]   instrument_id;
    logic [ID_W-1:0]   customer_id;
    logic              active;
    logic [TIME_W-1:0] updated_time;

    modport source (
        output valid, command, scope, instrument_id, customer_id, active, updated_time,
        input  ready
    );

    modport sink (
        input  valid, command, scope, instrument_id, customer_id, active, updated_time,
        output ready
    );
endinterface

FILE: hdl/krpm_out_if.sv
// Result channel of the kill rule block: valid/ready plus one result word.
// Depends on nothing beyond plain logic types.
interface krpm_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] decision;
    logic       table_full;

    modport source (
        output valid, decision, table_full,
        input  ready
    );

    modport sink (
        input  valid, decision, table_full,
        output ready
    );
endinterface

FILE: hdl/krpm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module krpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/krpm_judge.sv
// Rule evaluator: checks one stored rule per cycle while ctl.eval is set, against
// the order key, and keeps the best match so far. Depends on krpm_pkg.
module krpm_judge
    import krpm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  judge_ctl_t         ctl,
    input  rule_t              rule,
    input  logic [ID_W-1:0]    key_instrument,
    input  logic [ID_W-1:0]    key_customer,
    input  logic [TIME_W-1:0]  now_time,
    input  logic [LIMIT_W-1:0] stale_limit,
    output decision_t          decision
);

    logic              found_reg, found_next;
    logic [1:0]        rank_reg, rank_next;
    logic              stale_reg, stale_next;

    logic              match;
    logic [TIME_W:0]   age;
    logic              stale;
    logic              take;

    // Match and staleness of the rule on the read port
    always_comb
    begin
        unique case (scope_t'(rule.scope))
            SCOPE_ALL:        match = rule.active;
            SCOPE_INSTRUMENT: match = rule.active && (rule.instrument == key_instrument);
            SCOPE_CUSTOMER:   match = rule.active && (rule.customer == key_customer);
            default:          match = 1'b0;
        endcase
        // borrow out means the rule time lies in the future
        age   = {1'b0, now_time} - {1'b0, rule.upd_time};
        stale = age[TIME_W] || (age[TIME_W-1:0] > TIME_W'(stale_limit));
        // equal rank: a later rule wins unless it is fresh against a stale best
        take  = match && (!found_reg || (rule.scope > rank_reg) ||
                ((rule.scope == rank_reg) && (stale || !stale_reg)));
    end

    // Update the best match
    always_comb
    begin
        found_next = found_reg;
        rank_next  = rank_reg;
        stale_next = stale_reg;
        if (ctl.start)
        begin
            found_next = 1'b0;
        end
        else if (ctl.eval && take)
        begin
            found_next = 1'b1;
            rank_next  = rule.scope;
            stale_next = stale;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg  <= rank_next;
        stale_reg <= stale_next;
    end

    // Map the winner to a decision
    always_comb
    begin
        priority if (!found_reg)
            decision = DEC_ACCEPT;
        else if (stale_reg)
            decision = DEC_FAIL_CLOSED;
        else if (scope_t'(rank_reg) == SCOPE_CUSTOMER)
            decision = DEC_KILL_CUSTOMER;
        else if (scope_t'(rank_reg) == SCOPE_INSTRUMENT)
            decision = DEC_KILL_INSTRUMENT;
        else
            decision = DEC_KILL_ALL;
    end

endmodule

FILE: hdl/kill_rule_priority_match.sv
// Top level of the kill rule priority match block: sequencer, rule memory,
// configuration registers and result register. Depends on krpm_pkg,
// krpm_in_if, krpm_out_if, krpm_ram and krpm_judge.
//
//   channel  dir   handshake          payload
//   req      in    valid/ready        command, scope, instrument_id, customer_id,
//                                     active, updated_time
//   rsp      out   valid/ready        decision, table_full
//   apb      in    psel/penable       paddr[3:0], pwdata/prdata 64 bit,
//                                     stale_limit at 0x0, now_time at 0x8
//
// Clear and append complete on accept; their result word is registered in the cycle after.
// A judge runs through the accept, one memory read per stored rule through the
// single read port, the compare of the last rule and the loading of the result.
// A judge on an empty table answers accept without a scan.
// Reset empties the table and returns the configuration to its defaults; the
// memory holds stale words until written and needs no clearing pass.
// req.ready is low during a judge scan and while an untaken result would block.
module kill_rule_priority_match
    import krpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    krpm_in_if.sink               req,
    krpm_out_if.source            rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_addr_reg, scan_addr_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [ID_W-1:0]    key_instr_reg, key_instr_next;
    logic [ID_W-1:0]    key_cust_reg, key_cust_next;
    logic               out_valid_reg, out_valid_next;
    decision_t          out_dec_reg, out_dec_next;
    logic               out_full_reg, out_full_next;
    logic [LIMIT_W-1:0] stale_limit_reg;
    logic [TIME_W-1:0]  now_time_reg;

    logic               in_ready;
    logic               accept;
    logic               issue_live;
    logic               ram_we;
    rule_t              wr_rule;
    rule_t              rd_rule;
    judge_ctl_t         jctl;
    decision_t          judge_dec;
    logic               cfg_we;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_limit_reg <= STALE_LIMIT_RST;
            now_time_reg    <= NOW_TIME_RST;
        end
        else if (cfg_we)
        begin
            if (paddr[3] == CFG_IDX_STALE_LIMIT)
                stale_limit_reg <= pwdata[LIMIT_W-1:0];
            else
                now_time_reg <= pwdata[TIME_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[3] == CFG_IDX_STALE_LIMIT)
            prdata = CFG_DATA_W'(stale_limit_reg);
        else
            prdata = CFG_DATA_W'(now_time_reg);
    end

    // Handshake
    assign in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept     = req.valid && in_ready;
    assign req.ready  = in_ready;
    assign issue_live = (state_reg == ST_SCAN) && (scan_addr_reg < count_reg);
    assign ram_we     = accept && (cmd_t'(req.command) == CMD_APPEND) &&
                        (count_reg < CNT_W'(TABLE_DEPTH));

    assign wr_rule.scope      = req.scope;
    assign wr_rule.active     = req.active;
    assign wr_rule.instrument = req.instrument_id;
    assign wr_rule.customer   = req.customer_id;
    assign wr_rule.upd_time   = req.updated_time;

    assign rsp.valid      = out_valid_reg;
    assign rsp.decision   = out_dec_reg;
    assign rsp.table_full = out_full_reg;

    // Rule memory
    krpm_ram #(
        .WIDTH ($bits(rule_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (wr_rule),
        .raddr (scan_addr_reg[ADDR_W-1:0]),
        .rdata (rd_rule)
    );

    // Evaluator
    assign jctl.start = accept;
    assign jctl.eval  = rd_pend_reg;

    krpm_judge u_judge (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (jctl),
        .rule           (rd_rule),
        .key_instrument (key_instr_reg),
        .key_customer   (key_cust_reg),
        .now_time       (now_time_reg),
        .stale_limit    (stale_limit_reg),
        .decision       (judge_dec)
    );

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_addr_next = scan_addr_reg;
        rd_pend_next   = 1'b0;
        key_instr_next = key_instr_reg;
        key_cust_next  = key_cust_reg;
        out_dec_next   = out_dec_reg;
        out_full_next  = out_full_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    out_dec_next   = DEC_ACCEPT;
                    out_full_next  = 1'b0;
                    unique case (req.command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (ram_we)
                                count_next = count_reg + CNT_W'(1);
                            else
                                out_full_next = 1'b1;
                        end
                        CMD_JUDGE:
                        begin
                            key_instr_next = req.instrument_id;
                            key_cust_next  = req.customer_id;
                            scan_addr_next = '0;
                            // empty table answers accept at once
                            if (count_reg != '0)
                            begin
                                out_valid_next = 1'b0;
                                state_next     = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // advance the read address while rules remain
                if (issue_live)
                begin
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                    rd_pend_next   = 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    out_valid_next = 1'b1;
                    out_dec_next   = judge_dec;
                    out_full_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        key_instr_reg <= key_instr_next;
        key_cust_reg  <= key_cust_next;
        out_dec_reg   <= out_dec_next;
        out_full_reg  <= out_full_next;
    end

    // Checks
    a_scan_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !out_valid_reg)
        else $error("result word pending during a scan");

    a_scan_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |=> (state_reg == ST_SCAN) || out_valid_reg)
        else $error("scan ended without a result word");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("rule count beyond table depth");

    a_full_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_full_reg) |-> (out_dec_reg == DEC_ACCEPT))
        else $error("refused append carries a kill decision");

endmodule
